>>> hw/rtl/fbdc_pkg.sv
`timescale 1ns / 1ps

package fbdc_pkg;

	// Default word width of frequencies and powers
	localparam int DATA_WIDTH = 16;

	// Configuration port: six registers, one word apart
	localparam int APB_DATA_WIDTH = 32;
	localparam int APB_ADDR_WIDTH = 5;

	// Register reset values (Q3.12 power, mHz frequency)
	localparam int RST_POWER_UPPER      = 4096;
	localparam int RST_POWER_LOWER      = -4096;
	localparam int RST_FREQ_UPPER_UPPER = 200;
	localparam int RST_FREQ_UPPER_LOWER = 20;
	localparam int RST_FREQ_LOWER_UPPER = -20;
	localparam int RST_FREQ_LOWER_LOWER = -200;

	// Register map, word index
	typedef enum logic [2:0] {
		REG_POWER_UPPER      = 3'd0,
		REG_POWER_LOWER      = 3'd1,
		REG_FREQ_UPPER_UPPER = 3'd2,
		REG_FREQ_UPPER_LOWER = 3'd3,
		REG_FREQ_LOWER_UPPER = 3'd4,
		REG_FREQ_LOWER_LOWER = 3'd5
	} fbdc_reg_t;

	// Curve region, top down
	typedef enum logic [2:0] {
		RGN_HIGH_SAT  = 3'd0,
		RGN_HIGH_RAMP = 3'd1,
		RGN_DEADBAND  = 3'd2,
		RGN_LOW_RAMP  = 3'd3,
		RGN_LOW_SAT   = 3'd4
	} fbdc_region_t;

	// Control that travels alongside the ramp arithmetic
	typedef struct packed {
		fbdc_region_t region;
		logic         neg;
	} fbdc_ctl_t;

endpackage

>>> hw/rtl/fbdc_front.sv
`timescale 1ns / 1ps

// Region decode (stage 1) and ramp operand set-up (stage 2)
module fbdc_front #(
	parameter int DATA_WIDTH = fbdc_pkg::DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  logic signed [DATA_WIDTH-1:0] freq_deviation,
	input  logic signed [DATA_WIDTH-1:0] power_upper,
	input  logic signed [DATA_WIDTH-1:0] power_lower,
	input  logic signed [DATA_WIDTH-1:0] freq_upper_upper,
	input  logic signed [DATA_WIDTH-1:0] freq_upper_lower,
	input  logic signed [DATA_WIDTH-1:0] freq_lower_upper,
	input  logic signed [DATA_WIDTH-1:0] freq_lower_lower,
	output logic                         valid_s2,
	output logic [DATA_WIDTH-1:0]        mag_s2,
	output logic [DATA_WIDTH-1:0]        num_s2,
	output logic [DATA_WIDTH-1:0]        den_s2,
	output fbdc_pkg::fbdc_ctl_t          ctl_s2,
	output logic signed [DATA_WIDTH-1:0] direct_s2
);

	logic                         valid_s1;
	logic signed [DATA_WIDTH-1:0] freq_s1;
	fbdc_pkg::fbdc_region_t       region_s1;
	fbdc_pkg::fbdc_region_t       region_d;

	logic signed [DATA_WIDTH:0]   num_hi_d;
	logic signed [DATA_WIDTH:0]   den_hi_d;
	logic signed [DATA_WIDTH:0]   num_lo_d;
	logic signed [DATA_WIDTH:0]   den_lo_d;
	logic [DATA_WIDTH-1:0]        pow_d;
	logic [DATA_WIDTH-1:0]        mag_d;
	logic [DATA_WIDTH-1:0]        num_d;
	logic [DATA_WIDTH-1:0]        den_d;
	logic                         neg_d;
	logic signed [DATA_WIDTH-1:0] direct_d;

	// Top-down cascade of threshold tests
	always_comb begin
		if (freq_deviation > freq_upper_upper) begin
			region_d = fbdc_pkg::RGN_HIGH_SAT;
		end else if (freq_deviation > freq_upper_lower) begin
			region_d = fbdc_pkg::RGN_HIGH_RAMP;
		end else if (freq_deviation > freq_lower_upper) begin
			region_d = fbdc_pkg::RGN_DEADBAND;
		end else if (freq_deviation > freq_lower_lower) begin
			region_d = fbdc_pkg::RGN_LOW_RAMP;
		end else begin
			region_d = fbdc_pkg::RGN_LOW_SAT;
		end
	end

	// Differences are positive inside their ramp, so the low bits hold them unsigned
	assign num_hi_d = {freq_s1[DATA_WIDTH-1], freq_s1}
		- {freq_upper_lower[DATA_WIDTH-1], freq_upper_lower};
	assign den_hi_d = {freq_upper_upper[DATA_WIDTH-1], freq_upper_upper}
		- {freq_upper_lower[DATA_WIDTH-1], freq_upper_lower};
	assign num_lo_d = {freq_lower_upper[DATA_WIDTH-1], freq_lower_upper}
		- {freq_s1[DATA_WIDTH-1], freq_s1};
	assign den_lo_d = {freq_lower_upper[DATA_WIDTH-1], freq_lower_upper}
		- {freq_lower_lower[DATA_WIDTH-1], freq_lower_lower};

	always_comb begin
		pow_d    = '0;
		num_d    = '0;
		den_d    = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
		direct_d = '0;
		case (region_s1)
			fbdc_pkg::RGN_HIGH_SAT: begin
				direct_d = power_lower;
			end
			fbdc_pkg::RGN_HIGH_RAMP: begin
				pow_d = power_lower;
				num_d = num_hi_d[DATA_WIDTH-1:0];
				den_d = den_hi_d[DATA_WIDTH-1:0];
			end
			fbdc_pkg::RGN_LOW_RAMP: begin
				pow_d = power_upper;
				num_d = num_lo_d[DATA_WIDTH-1:0];
				den_d = den_lo_d[DATA_WIDTH-1:0];
			end
			fbdc_pkg::RGN_LOW_SAT: begin
				direct_d = power_upper;
			end
			default: begin
				direct_d = '0;
			end
		endcase
		// Magnitude of the most negative power wraps onto its own unsigned value
		neg_d = pow_d[DATA_WIDTH-1];
		mag_d = neg_d ? (~pow_d + 1'b1) : pow_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			freq_s1          <= freq_deviation;
			region_s1        <= region_d;
			mag_s2           <= mag_d;
			num_s2           <= num_d;
			den_s2           <= den_d;
			ctl_s2.region    <= region_s1;
			ctl_s2.neg       <= neg_d;
			direct_s2        <= direct_d;
		end
	end

endmodule

>>> hw/rtl/fbdc_ramp.sv
`timescale 1ns / 1ps

// Magnitude product, then a restoring divider that settles one quotient bit per stage
module fbdc_ramp #(
	parameter int DATA_WIDTH = fbdc_pkg::DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  logic [DATA_WIDTH-1:0]        mag,
	input  logic [DATA_WIDTH-1:0]        num,
	input  logic [DATA_WIDTH-1:0]        den,
	input  fbdc_pkg::fbdc_ctl_t          ctl,
	input  logic signed [DATA_WIDTH-1:0] direct,
	output logic                         out_valid,
	output logic [DATA_WIDTH-1:0]        quo,
	output fbdc_pkg::fbdc_ctl_t          out_ctl,
	output logic signed [DATA_WIDTH-1:0] out_direct
);

	localparam int NSTG = DATA_WIDTH + 1;

	logic [2*DATA_WIDTH-1:0]      prod_d;

	logic                         vld_s    [NSTG];
	logic [DATA_WIDTH-1:0]        rem_s    [NSTG];
	logic [DATA_WIDTH-1:0]        lo_s     [NSTG];
	logic [DATA_WIDTH-1:0]        quo_s    [NSTG];
	logic [DATA_WIDTH-1:0]        den_s    [NSTG];
	fbdc_pkg::fbdc_ctl_t          ctl_s    [NSTG];
	logic signed [DATA_WIDTH-1:0] direct_s [NSTG];

	assign prod_d = mag * num;

	// Stage zero: the product splits into partial remainder and pending low bits.
	// num <= den keeps the quotient below 2^DATA_WIDTH, so the high half is below den.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]    <= prod_d[2*DATA_WIDTH-1:DATA_WIDTH];
			lo_s[0]     <= prod_d[DATA_WIDTH-1:0];
			quo_s[0]    <= '0;
			den_s[0]    <= den;
			ctl_s[0]    <= ctl;
			direct_s[0] <= direct;
		end
	end

	for (genvar k = 1; k < NSTG; k++) begin : g_div
		logic [DATA_WIDTH:0] trial;
		logic [DATA_WIDTH:0] diff;
		logic                ge;

		assign trial = {rem_s[k-1], lo_s[k-1][DATA_WIDTH-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};
		assign ge    = (trial >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]    <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
				lo_s[k]     <= {lo_s[k-1][DATA_WIDTH-2:0], 1'b0};
				quo_s[k]    <= {quo_s[k-1][DATA_WIDTH-2:0], ge};
				den_s[k]    <= den_s[k-1];
				ctl_s[k]    <= ctl_s[k-1];
				direct_s[k] <= direct_s[k-1];
			end
		end
	end

	assign out_valid  = vld_s[NSTG-1];
	assign quo        = quo_s[NSTG-1];
	assign out_ctl    = ctl_s[NSTG-1];
	assign out_direct = direct_s[NSTG-1];

endmodule

>>> hw/rtl/frequency_bias_droop_curve.sv
`timescale 1ns / 1ps

// Channel   Handshake                  Beat payload
// freq      freq_valid / freq_ready    freq_deviation (signed, mHz)
// bias      bias_valid / bias_ready    power_bias (signed Q3.12), region
// config    psel/penable/pwrite/pready paddr, pwdata, prdata (APB-style, six words)
//
// One beat per cycle in and out while no bias beat is stalled; the restoring
// divider settles one quotient bit per stage.
// Reset clears every valid bit and loads the register defaults; no clearing pass.
// A stalled bias beat holds the whole pipeline, so freq_ready falls with it and
// nothing is dropped or repeated.
module frequency_bias_droop_curve #(
	parameter int DATA_WIDTH = fbdc_pkg::DATA_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// frequency beats
	input  logic                                  freq_valid,
	output logic                                  freq_ready,
	input  logic signed [DATA_WIDTH-1:0]          freq_deviation,
	// bias beats
	output logic                                  bias_valid,
	input  logic                                  bias_ready,
	output logic signed [DATA_WIDTH-1:0]          power_bias,
	output logic [2:0]                            region,
	// configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [fbdc_pkg::APB_ADDR_WIDTH-1:0]   paddr,
	input  logic [fbdc_pkg::APB_DATA_WIDTH-1:0]   pwdata,
	output logic [fbdc_pkg::APB_DATA_WIDTH-1:0]   prdata,
	output logic                                  pready
);

	localparam logic signed [DATA_WIDTH:0] SAT_HI = {2'b00, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH:0] SAT_LO = {2'b11, {(DATA_WIDTH-1){1'b0}}};

	// Configuration registers
	logic signed [DATA_WIDTH-1:0] power_upper_q;
	logic signed [DATA_WIDTH-1:0] power_lower_q;
	logic signed [DATA_WIDTH-1:0] freq_upper_upper_q;
	logic signed [DATA_WIDTH-1:0] freq_upper_lower_q;
	logic signed [DATA_WIDTH-1:0] freq_lower_upper_q;
	logic signed [DATA_WIDTH-1:0] freq_lower_lower_q;

	fbdc_pkg::fbdc_reg_t          reg_idx;
	logic                         wr_en;

	// Pipeline links
	logic                         adv;
	logic                         valid_s2;
	logic [DATA_WIDTH-1:0]        mag_s2;
	logic [DATA_WIDTH-1:0]        num_s2;
	logic [DATA_WIDTH-1:0]        den_s2;
	fbdc_pkg::fbdc_ctl_t          ctl_s2;
	logic signed [DATA_WIDTH-1:0] direct_s2;

	logic                         div_valid;
	logic [DATA_WIDTH-1:0]        div_quo;
	fbdc_pkg::fbdc_ctl_t          div_ctl;
	logic signed [DATA_WIDTH-1:0] div_direct;

	logic signed [DATA_WIDTH:0]   ramp_ext;
	logic signed [DATA_WIDTH:0]   ramp_signed;
	logic signed [DATA_WIDTH-1:0] ramp_sat;
	logic signed [DATA_WIDTH-1:0] bias_d;

	// Output register
	logic                         bias_valid_q;
	logic signed [DATA_WIDTH-1:0] power_bias_q;
	fbdc_pkg::fbdc_region_t       region_q;

	// ---------------------------------------------------------------------
	// Configuration port: zero-wait writes, word index from paddr[4:2]
	// ---------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = fbdc_pkg::fbdc_reg_t'(paddr[fbdc_pkg::APB_ADDR_WIDTH-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_upper_q      <= DATA_WIDTH'(fbdc_pkg::RST_POWER_UPPER);
			power_lower_q      <= DATA_WIDTH'(fbdc_pkg::RST_POWER_LOWER);
			freq_upper_upper_q <= DATA_WIDTH'(fbdc_pkg::RST_FREQ_UPPER_UPPER);
			freq_upper_lower_q <= DATA_WIDTH'(fbdc_pkg::RST_FREQ_UPPER_LOWER);
			freq_lower_upper_q <= DATA_WIDTH'(fbdc_pkg::RST_FREQ_LOWER_UPPER);
			freq_lower_lower_q <= DATA_WIDTH'(fbdc_pkg::RST_FREQ_LOWER_LOWER);
		end else if (wr_en) begin
			unique case (reg_idx)
				fbdc_pkg::REG_POWER_UPPER:      power_upper_q      <= pwdata[DATA_WIDTH-1:0];
				fbdc_pkg::REG_POWER_LOWER:      power_lower_q      <= pwdata[DATA_WIDTH-1:0];
				fbdc_pkg::REG_FREQ_UPPER_UPPER: freq_upper_upper_q <= pwdata[DATA_WIDTH-1:0];
				fbdc_pkg::REG_FREQ_UPPER_LOWER: freq_upper_lower_q <= pwdata[DATA_WIDTH-1:0];
				fbdc_pkg::REG_FREQ_LOWER_UPPER: freq_lower_upper_q <= pwdata[DATA_WIDTH-1:0];
				fbdc_pkg::REG_FREQ_LOWER_LOWER: freq_lower_lower_q <= pwdata[DATA_WIDTH-1:0];
				default: begin
					// drop writes to unmapped words
				end
			endcase
		end
	end

	// Read back sign-extended to the bus width
	always_comb begin
		unique case (reg_idx)
			fbdc_pkg::REG_POWER_UPPER:      prdata = 32'(power_upper_q);
			fbdc_pkg::REG_POWER_LOWER:      prdata = 32'(power_lower_q);
			fbdc_pkg::REG_FREQ_UPPER_UPPER: prdata = 32'(freq_upper_upper_q);
			fbdc_pkg::REG_FREQ_UPPER_LOWER: prdata = 32'(freq_upper_lower_q);
			fbdc_pkg::REG_FREQ_LOWER_UPPER: prdata = 32'(freq_lower_upper_q);
			fbdc_pkg::REG_FREQ_LOWER_LOWER: prdata = 32'(freq_lower_lower_q);
			default:                        prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Pipeline: every stage moves together; hold all of it while the output
	// register is full and not being taken.
	// ---------------------------------------------------------------------
	assign adv        = !bias_valid_q || bias_ready;
	assign freq_ready = adv;

	fbdc_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.adv              (adv),
		.in_valid         (freq_valid),
		.freq_deviation   (freq_deviation),
		.power_upper      (power_upper_q),
		.power_lower      (power_lower_q),
		.freq_upper_upper (freq_upper_upper_q),
		.freq_upper_lower (freq_upper_lower_q),
		.freq_lower_upper (freq_lower_upper_q),
		.freq_lower_lower (freq_lower_lower_q),
		.valid_s2         (valid_s2),
		.mag_s2           (mag_s2),
		.num_s2           (num_s2),
		.den_s2           (den_s2),
		.ctl_s2           (ctl_s2),
		.direct_s2        (direct_s2)
	);

	fbdc_ramp #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ramp (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (valid_s2),
		.mag        (mag_s2),
		.num        (num_s2),
		.den        (den_s2),
		.ctl        (ctl_s2),
		.direct     (direct_s2),
		.out_valid  (div_valid),
		.quo        (div_quo),
		.out_ctl    (div_ctl),
		.out_direct (div_direct)
	);

	// Restore the sign, saturate, and pick the ramp or the flat value.
	// The quotient never exceeds the power magnitude, so the clamp is a guard.
	assign ramp_ext    = {1'b0, div_quo};
	assign ramp_signed = div_ctl.neg ? -ramp_ext : ramp_ext;

	always_comb begin
		if (ramp_signed > SAT_HI) begin
			ramp_sat = SAT_HI[DATA_WIDTH-1:0];
		end else if (ramp_signed < SAT_LO) begin
			ramp_sat = SAT_LO[DATA_WIDTH-1:0];
		end else begin
			ramp_sat = ramp_signed[DATA_WIDTH-1:0];
		end
	end

	always_comb begin
		case (div_ctl.region) inside
			fbdc_pkg::RGN_HIGH_RAMP, fbdc_pkg::RGN_LOW_RAMP: bias_d = ramp_sat;
			default:                                          bias_d = div_direct;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_valid_q <= 1'b0;
		end else if (adv) begin
			bias_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			power_bias_q <= bias_d;
			region_q     <= div_ctl.region;
		end
	end

	assign bias_valid = bias_valid_q;
	assign power_bias = power_bias_q;
	assign region     = region_q;

endmodule

>>> hw/rtl/fbdc_checker.sv
`timescale 1ns / 1ps

module fbdc_checker #(
	parameter int DATA_WIDTH = fbdc_pkg::DATA_WIDTH
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         freq_ready,
	input logic                         bias_valid,
	input logic                         bias_ready,
	input logic signed [DATA_WIDTH-1:0] power_bias,
	input logic [2:0]                   region
);

	// A stalled bias beat holds its payload
	a_bias_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bias_valid && !bias_ready |=> bias_valid && $stable(power_bias) && $stable(region))
		else $error("bias beat changed while stalled");

	// Only the five curve regions may be reported
	a_region_range: assert property (@(posedge clk) disable iff (!arst_n)
		bias_valid |-> region <= fbdc_pkg::RGN_LOW_SAT)
		else $error("region code out of range");

	// Deadband gives zero bias
	a_deadband_zero: assert property (@(posedge clk) disable iff (!arst_n)
		bias_valid && region == fbdc_pkg::RGN_DEADBAND |-> power_bias == '0)
		else $error("non-zero bias in deadband");

	// A held output stalls the input side
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		bias_valid && !bias_ready |-> !freq_ready)
		else $error("input taken while output stalled");

endmodule

bind frequency_bias_droop_curve fbdc_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_fbdc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.freq_ready (freq_ready),
	.bias_valid (bias_valid),
	.bias_ready (bias_ready),
	.power_bias (power_bias),
	.region     (region)
);

>>> sim/droop_bias_checker.sv
`timescale 1ns / 1ps

module droop_bias_checker
	import fbdc_pkg::*;
(
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                freq_valid,
	input  logic                                freq_ready,
	input  logic signed [DATA_WIDTH-1:0]        freq_deviation,
	input  logic                                bias_valid,
	input  logic                                bias_ready,
	input  logic signed [DATA_WIDTH-1:0]        power_bias,
	input  logic [2:0]                          region,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [APB_ADDR_WIDTH-1:0]           paddr,
	input  logic [APB_DATA_WIDTH-1:0]           pwdata,
	output int                                  mismatches,
	output int                                  pending
);

	localparam longint BIAS_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
	localparam longint BIAS_MIN = -BIAS_MAX - 1;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] freq;
		logic signed [DATA_WIDTH-1:0] power;
		fbdc_region_t                 rgn;
	} bias_beat_t;

	// shadow of the curve registers, tracked from the configuration bus
	logic signed [DATA_WIDTH-1:0] pwr_upper, pwr_lower;
	logic signed [DATA_WIDTH-1:0] f_uu, f_ul, f_lu, f_ll;

	bias_beat_t bias_due [$];
	int         bad;

	// p * num / den, truncated toward zero
	function automatic longint ramp_share(input longint p, input longint num,
		input longint den);
		longint q;
		q = (p < 0 ? -p : p) * num / den;
		return p < 0 ? -q : q;
	endfunction

	function automatic bias_beat_t droop_bias_of(input logic signed [DATA_WIDTH-1:0] f);
		bias_beat_t b;
		longint     lvl;
		b.freq = f;
		if (f > f_uu) begin
			lvl   = pwr_lower;
			b.rgn = RGN_HIGH_SAT;
		end else if (f > f_ul) begin
			lvl   = ramp_share(pwr_lower, longint'(f) - longint'(f_ul),
				longint'(f_uu) - longint'(f_ul));
			b.rgn = RGN_HIGH_RAMP;
		end else if (f > f_lu) begin
			lvl   = 0;
			b.rgn = RGN_DEADBAND;
		end else if (f > f_ll) begin
			lvl   = ramp_share(pwr_upper, longint'(f_lu) - longint'(f),
				longint'(f_lu) - longint'(f_ll));
			b.rgn = RGN_LOW_RAMP;
		end else begin
			lvl   = pwr_upper;
			b.rgn = RGN_LOW_SAT;
		end
		if (lvl > BIAS_MAX)
			lvl = BIAS_MAX;
		else if (lvl < BIAS_MIN)
			lvl = BIAS_MIN;
		b.power = lvl[DATA_WIDTH-1:0];
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bias_beat_t want;
		if (!arst_n) begin
			pwr_upper  <= DATA_WIDTH'(RST_POWER_UPPER);
			pwr_lower  <= DATA_WIDTH'(RST_POWER_LOWER);
			f_uu       <= DATA_WIDTH'(RST_FREQ_UPPER_UPPER);
			f_ul       <= DATA_WIDTH'(RST_FREQ_UPPER_LOWER);
			f_lu       <= DATA_WIDTH'(RST_FREQ_LOWER_UPPER);
			f_ll       <= DATA_WIDTH'(RST_FREQ_LOWER_LOWER);
			bias_due.delete();
			bad        = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_WIDTH-1:2])
					REG_POWER_UPPER:      pwr_upper <= pwdata[DATA_WIDTH-1:0];
					REG_POWER_LOWER:      pwr_lower <= pwdata[DATA_WIDTH-1:0];
					REG_FREQ_UPPER_UPPER: f_uu      <= pwdata[DATA_WIDTH-1:0];
					REG_FREQ_UPPER_LOWER: f_ul      <= pwdata[DATA_WIDTH-1:0];
					REG_FREQ_LOWER_UPPER: f_lu      <= pwdata[DATA_WIDTH-1:0];
					REG_FREQ_LOWER_LOWER: f_ll      <= pwdata[DATA_WIDTH-1:0];
					default: ;
				endcase
			end
			if (bias_valid && bias_ready) begin
				if (bias_due.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("%0t: bias beat with none due: power_bias %0d region %0d",
							$realtime, power_bias, region);
				end else begin
					want = bias_due.pop_front();
					if (power_bias !== want.power || region !== want.rgn) begin
						bad++;
						if (bad <= 10)
							$display("%0t: freq %0d expected %0d region %0d, got %0d region %0d",
								$realtime, want.freq, want.power, want.rgn, power_bias, region);
					end
				end
			end
			if (freq_valid && freq_ready)
				bias_due.push_back(droop_bias_of(freq_deviation));
			mismatches <= bad;
			pending    <= bias_due.size();
		end
	end

endmodule

>>> sim/frequency_bias_droop_curve_tb.sv
`timescale 1ns / 1ps

module frequency_bias_droop_curve_tb;

	import fbdc_pkg::*;

	// pipeline depth of the block: one stage per quotient bit plus four
	localparam int SETTLE       = DATA_WIDTH + 4;
	localparam int RANDOM_ITEMS = 162;
	// the receiver goes quiet once this many bias beats have passed
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 90;
	localparam logic signed [DATA_WIDTH-1:0] FREQ_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [DATA_WIDTH-1:0] FREQ_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	logic                         clk;
	logic                         arst_n;
	logic                         freq_valid;
	logic                         freq_ready;
	logic signed [DATA_WIDTH-1:0] freq_deviation;
	logic                         bias_valid;
	logic                         bias_ready;
	logic signed [DATA_WIDTH-1:0] power_bias;
	logic [2:0]                   region;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [APB_ADDR_WIDTH-1:0]    paddr;
	logic [APB_DATA_WIDTH-1:0]    pwdata;
	logic [APB_DATA_WIDTH-1:0]    prdata;
	logic                         pready;

	int mismatches;
	int pending;

	// receiver follows this to drop its random stalls during the steady phase
	logic steady;

	// thresholds currently loaded, used only to aim stimulus at the region edges
	logic signed [DATA_WIDTH-1:0] curve_thr [4];

	// default curve: both extremes, every edge and its neighbours, each region
	int probe_freqs [21] = '{-32768, 32767, 0, -1, 1, 201, 200, 199, 110, 21, 20, 19,
		-19, -20, -21, -110, -199, -200, -201, 12345, -12345};

	frequency_bias_droop_curve i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.freq_valid     (freq_valid),
		.freq_ready     (freq_ready),
		.freq_deviation (freq_deviation),
		.bias_valid     (bias_valid),
		.bias_ready     (bias_ready),
		.power_bias     (power_bias),
		.region         (region),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	droop_bias_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.freq_valid     (freq_valid),
		.freq_ready     (freq_ready),
		.freq_deviation (freq_deviation),
		.bias_valid     (bias_valid),
		.bias_ready     (bias_ready),
		.power_bias     (power_bias),
		.region         (region),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Half the picks land within four counts of a threshold, a tenth on the
	// extremes of the field, the rest anywhere in range.
	function automatic logic signed [DATA_WIDTH-1:0] pick_freq();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10)
			return $urandom_range(1) ? FREQ_MAX : FREQ_MIN;
		else if (sel < 60)
			return DATA_WIDTH'(curve_thr[$urandom_range(3)] + (int'($urandom_range(8)) - 4));
		else
			return DATA_WIDTH'($urandom);
	endfunction

	// Offer one frequency beat and hold it until the block takes it. Gaps go
	// in front of the beat so that they fall on every phase of the pipeline.
	task automatic offer_freq(input logic signed [DATA_WIDTH-1:0] f, input bit no_gaps);
		while (!no_gaps && $urandom_range(99) < 26) begin
			freq_valid <= 1'b0;
			@(posedge clk);
		end
		freq_valid     <= 1'b1;
		freq_deviation <= f;
		do @(posedge clk); while (!freq_ready);
	endtask

	// Setup phase, access phase, then an idle phase with psel low so that back-to-back
	// writes never move psel twice in one step.
	task automatic write_reg(input fbdc_reg_t idx, input logic signed [DATA_WIDTH-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DATA_WIDTH'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Load a whole curve; only ever called with nothing in flight.
	task automatic load_curve(input int pu, pl, fuu, ful, flu, fll);
		write_reg(REG_POWER_UPPER, DATA_WIDTH'(pu));
		write_reg(REG_POWER_LOWER, DATA_WIDTH'(pl));
		write_reg(REG_FREQ_UPPER_UPPER, DATA_WIDTH'(fuu));
		write_reg(REG_FREQ_UPPER_LOWER, DATA_WIDTH'(ful));
		write_reg(REG_FREQ_LOWER_UPPER, DATA_WIDTH'(flu));
		write_reg(REG_FREQ_LOWER_LOWER, DATA_WIDTH'(fll));
		curve_thr = '{DATA_WIDTH'(fuu), DATA_WIDTH'(ful), DATA_WIDTH'(flu), DATA_WIDTH'(fll)};
	endtask

	// Random beats against the loaded curve, then drain: the sender pauses
	// until every bias beat it caused has come back. Let the checker's registered
	// count update first so that it already holds the last beat taken.
	task automatic sweep_curve(input bit no_gaps);
		steady <= no_gaps;
		repeat (RANDOM_ITEMS)
			offer_freq(pick_freq(), no_gaps);
		freq_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		steady <= 1'b0;
	endtask

	// Receiver: random stalls, none while steady, and one long hold-off part
	// way through so that the pipeline fills and back-pressures the sender.
	initial begin
		int beats;
		bit held;
		beats      = 0;
		held       = 1'b0;
		bias_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (bias_valid && bias_ready)
				beats++;
			if (!held && beats >= HOLD_AT) begin
				held = 1'b1;
				bias_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				bias_ready <= steady || ($urandom_range(99) >= 26);
			end
		end
	end

	initial begin
		int t [$];
		arst_n         = 1'b0;
		freq_valid     = 1'b0;
		freq_deviation = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		steady         = 1'b0;
		curve_thr      = '{DATA_WIDTH'(RST_FREQ_UPPER_UPPER), DATA_WIDTH'(RST_FREQ_UPPER_LOWER),
			DATA_WIDTH'(RST_FREQ_LOWER_UPPER), DATA_WIDTH'(RST_FREQ_LOWER_LOWER)};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset curve: directed probes, then random beats
		foreach (probe_freqs[k])
			offer_freq(DATA_WIDTH'(probe_freqs[k]), 1'b0);
		sweep_curve(1'b0);

		// widest high ramp: divisor 65535, full-scale powers
		load_curve(32767, -32768, 32767, -32768, -32768, -32768);
		sweep_curve(1'b0);

		// steepest ramps with inverted powers; no idling on either side
		load_curve(-32768, 32767, 1000, 999, -999, -1000);
		sweep_curve(1'b1);

		// thresholds out of order: empty regions never chosen
		load_curve(12345, -23456, -100, 100, 300, -300);
		sweep_curve(1'b0);

		// widest low ramp, most negative power upper
		load_curve(-32768, 0, 32767, 32767, 32767, -32768);
		sweep_curve(1'b0);

		// random powers over sorted random thresholds
		repeat (4) t.push_back(int'($urandom_range(65535)) - 32768);
		t.rsort();
		load_curve(int'($urandom), int'($urandom), t[0], t[1], t[2], t[3]);
		sweep_curve(1'b0);

		// all zero: flat curve, every threshold on top of the others
		load_curve(0, 0, 0, 0, 0, 0);
		sweep_curve(1'b0);

		repeat (2 * SETTLE) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("frequency_bias_droop_curve_tb: clean");
		else
			$display("frequency_bias_droop_curve_tb: errors");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("frequency_bias_droop_curve_tb: errors");
		$finish;
	end

endmodule

>>> frequency_bias_droop_curve.f
hw/rtl/fbdc_pkg.sv
hw/rtl/fbdc_front.sv
hw/rtl/fbdc_ramp.sv
hw/rtl/frequency_bias_droop_curve.sv
hw/rtl/fbdc_checker.sv
sim/droop_bias_checker.sv
sim/frequency_bias_droop_curve_tb.sv
